// ----- hdl/lpht_pkg.sv -----
// ----------------------------------------------------------------------------
// lpht_pkg: shared types and constants of the linear probe hash table
// Field widths, operation and status codes, slot marks, state encodings and
// the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lpht_pkg;

  localparam int KIND_W  = 2;
  localparam int KEY_W   = 64;
  localparam int VAL_W   = 32;
  localparam int CNT_W   = 9;
  localparam int STAT_W  = 2;
  localparam int MARK_W  = 2;
  localparam int HASH_W  = 64;

  localparam logic [KIND_W-1:0] KIND_GET    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SET    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_RSVD   = 2'd3;

  localparam logic [CNT_W-1:0]  MAX_ENTRIES_RST = 9'd204;
  localparam logic [HASH_W-1:0] DJB2_SEED       = 64'd5381;

  typedef enum logic [MARK_W-1:0] {
    MARK_EMPTY = 2'd0,
    MARK_LIVE  = 2'd1,
    MARK_TOMB  = 2'd2
  } mark_e;

  typedef enum logic [STAT_W-1:0] {
    STATUS_DONE   = 2'd0,
    STATUS_ABSENT = 2'd1,
    STATUS_FULL   = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_PROBE,
    ST_COMMIT
  } ctrl_state_e;

  typedef enum logic [2:0] {
    HPH_IDLE,
    HPH_HASH,
    HPH_FOLD,
    HPH_QUOT,
    HPH_REM,
    HPH_FIX
  } hash_phase_e;

  typedef struct packed {
    logic    load;
    logic    clr_step;
    logic    load_home;
    logic    probe;
    logic    advance;
    logic    commit;
    logic    wr_key;
    logic    wr_val;
    logic    wr_mark;
    mark_e   mark;
    logic    wsel_free;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    vout_sel;
    status_e status;
  } ctl_cmd_t;

  typedef struct packed {
    logic              hash_done;
    logic              mark_live;
    logic              mark_empty;
    logic              key_match;
    logic              last_probe;
    logic              last_idx;
    logic              found;
    logic              free_valid;
    logic              full;
    logic              out_free;
    logic [KIND_W-1:0] kind;
  } dp_stat_t;

endpackage

// ----- hdl/lpht_if.sv -----
// ----------------------------------------------------------------------------
// lpht_if: request and response channels of the hash table
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lpht_req_if;
  logic                        valid;
  logic                        ready;
  logic [lpht_pkg::KIND_W-1:0] kind;
  logic [lpht_pkg::KEY_W-1:0]  key;
  logic [lpht_pkg::VAL_W-1:0]  value;

  modport source (output valid, kind, key, value, input ready);
  modport sink   (input valid, kind, key, value, output ready);
endinterface

interface lpht_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        found;
  logic [lpht_pkg::VAL_W-1:0]  value_out;
  logic [lpht_pkg::STAT_W-1:0] status;
  logic [lpht_pkg::CNT_W-1:0]  entry_count_out;

  modport source (output valid, found, value_out, status, entry_count_out, input ready);
  modport sink   (input valid, found, value_out, status, entry_count_out, output ready);
endinterface

// ----- hdl/linear_probe_hash_table_core.sv -----
// ----------------------------------------------------------------------------
// linear_probe_hash_table_core: key-value store with linear probing
// Get, set and remove on keys of up to KEY_BYTES bytes, djb2-hashed, held in
// SLOTS slots with open addressing and tombstones; inserts are capped by the
// max_entries register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Each request beat carries kind (0 get, 1 set, 2 remove; 3 behaves as get),
// a zero-padded key with its first character in bits 7:0, and a value used
// by set. Every request yields exactly one response beat: found, the stored
// value for a hit get, a status (done, absent, full) and the live entry count
// after the operation. After reset the block sweeps the slot mark RAM, slot by
// slot, before it raises ready; cfg writes are taken during the sweep. With
// SLOTS a power of two a request runs from one accept to the next through
// the accept, the home slot, the probes, one per cycle through the single
// read port of the slot RAMs until a slot decides, and the commit. For other
// SLOTS values the home slot comes from a byte-serial hash, folds of the
// upper hash word (at most four folds), a reciprocal-multiply remainder in
// quotient, remainder and fix steps and the done flag, in place of the
// registered hash of the low bits. The response sits in an output register,
// so the next request is accepted while it waits; commit holds only if the
// previous response has not yet been taken.

module linear_probe_hash_table_core #(
  parameter int SLOTS       = 256,
  parameter int KEY_BYTES   = 8,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [lpht_pkg::CNT_W-1:0] cfg_wdata_i,
  lpht_req_if.sink                   req_i,
  lpht_rsp_if.source                 rsp_o
);

  lpht_pkg::ctl_cmd_t cmd;
  lpht_pkg::dp_stat_t stat;

  // controller: sequence clear, hash, probe and commit
  lpht_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // datapath: slot RAMs, probe state, counters and the response register
  lpht_dp #(
    .SLOTS       (SLOTS),
    .KEY_BYTES   (KEY_BYTES),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .kind_i        (req_i.kind),
    .key_i         (req_i.key),
    .value_i       (req_i.value),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .rsp_ready_i   (rsp_o.ready),
    .rsp_valid_o   (rsp_o.valid),
    .found_o       (rsp_o.found),
    .value_out_o   (rsp_o.value_out),
    .status_o      (rsp_o.status),
    .entry_count_o (rsp_o.entry_count_out)
  );

endmodule

// ----- hdl/lpht_ram.sv -----
// ----------------------------------------------------------------------------
// lpht_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- hdl/lpht_hash.sv -----
// ----------------------------------------------------------------------------
// lpht_hash: djb2 home slot unit
// Power-of-two table: low hash bits in one registered step. Otherwise a
// byte-serial 64-bit hash, folds of the upper word by 2^32 mod SLOTS and a
// reciprocal-multiply remainder with one corrective subtract.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpht_hash #(
  parameter int SLOTS     = 256,
  parameter int KEY_BYTES = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [lpht_pkg::KEY_W-1:0]   key_i,
  output logic                         done_o,
  output logic [$clog2(SLOTS)-1:0]     home_o
);

  localparam int IDXW   = $clog2(SLOTS);
  localparam int HW     = lpht_pkg::HASH_W;
  localparam logic [HW-1:0] SEED = lpht_pkg::DJB2_SEED;
  localparam bit POW2 = ((SLOTS & (SLOTS - 1)) == 0);

  if (POW2) begin : g_pow2
    logic [IDXW-1:0] h_c;
    logic [IDXW-1:0] home_q;
    logic            done_q;
    logic            alive;

    // only the low bits survive the modulo, so hash at index width
    always_comb begin
      h_c   = SEED[IDXW-1:0];
      alive = 1'b1;
      for (int i = 0; i < KEY_BYTES; i++) begin
        if (key_i[8*i +: 8] == 8'd0) begin
          alive = 1'b0;
        end
        if (alive) begin
          h_c = h_c + (h_c << 5) + IDXW'(key_i[8*i +: 8]);
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        done_q <= 1'b0;
      end else begin
        done_q <= start_i;
      end
    end

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        home_q <= h_c;
      end
    end

    assign done_o = done_q;
    assign home_o = home_q;
  end else begin : g_serial
    localparam logic [IDXW:0]   SLOTS_W = (IDXW + 1)'(SLOTS);
    // 2^32 mod SLOTS folds the upper word; MU is the floor reciprocal of SLOTS
    localparam logic [IDXW-1:0] FOLD_C  = IDXW'((64'd1 << 32) % 64'(SLOTS));
    localparam logic [31:0]     MU      = 32'((64'd1 << 32) / 64'(SLOTS));

    lpht_pkg::hash_phase_e ph_q, ph_d;
    logic                  done_q;
    logic [HW-1:0]         h_q;
    logic [HW-1:0]         kb_q;
    logic [31:0]           quot_q;
    logic [IDXW:0]         rem_q;
    logic [IDXW-1:0]       home_q;
    logic [31+IDXW:0]      fold_prod;
    logic [63:0]           quot_prod;
    logic [IDXW:0]         qs_low;

    assign fold_prod = h_q[HW-1:32] * FOLD_C;
    assign quot_prod = h_q[31:0] * MU;
    // the remainder estimate is below 2*SLOTS, so low bits of q*SLOTS suffice
    assign qs_low    = quot_q[IDXW:0] * SLOTS_W;

    always_comb begin
      ph_d = ph_q;
      unique case (ph_q)
        lpht_pkg::HPH_IDLE: if (start_i) ph_d = lpht_pkg::HPH_HASH;
        lpht_pkg::HPH_HASH: if (kb_q[7:0] == 8'd0) ph_d = lpht_pkg::HPH_FOLD;
        lpht_pkg::HPH_FOLD: if (h_q[HW-1:32] == '0) ph_d = lpht_pkg::HPH_QUOT;
        lpht_pkg::HPH_QUOT: ph_d = lpht_pkg::HPH_REM;
        lpht_pkg::HPH_REM:  ph_d = lpht_pkg::HPH_FIX;
        lpht_pkg::HPH_FIX:  ph_d = lpht_pkg::HPH_IDLE;
        default:            ph_d = lpht_pkg::HPH_IDLE;
      endcase
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ph_q   <= lpht_pkg::HPH_IDLE;
        done_q <= 1'b0;
      end else begin
        ph_q   <= ph_d;
        done_q <= (ph_q == lpht_pkg::HPH_FIX);
      end
    end

    always_ff @(posedge clk_i) begin
      unique case (ph_q)
        lpht_pkg::HPH_IDLE: begin
          if (start_i) begin
            h_q  <= SEED;
            kb_q <= key_i;
          end
        end
        lpht_pkg::HPH_HASH: begin
          // key is normalized: the first zero byte ends it
          if (kb_q[7:0] != 8'd0) begin
            h_q  <= h_q + (h_q << 5) + HW'(kb_q[7:0]);
            kb_q <= kb_q >> 8;
          end
        end
        lpht_pkg::HPH_FOLD: begin
          // at most four folds bring the hash below 2^32
          if (h_q[HW-1:32] != '0) begin
            h_q <= HW'(fold_prod) + HW'(h_q[31:0]);
          end
        end
        lpht_pkg::HPH_QUOT: begin
          quot_q <= quot_prod[63:32];
        end
        lpht_pkg::HPH_REM: begin
          rem_q <= h_q[IDXW:0] - qs_low;
        end
        lpht_pkg::HPH_FIX: begin
          home_q <= (rem_q >= SLOTS_W) ? IDXW'(rem_q - SLOTS_W) : rem_q[IDXW-1:0];
        end
        default: begin
          h_q <= h_q;
        end
      endcase
    end

    assign done_o = done_q;
    assign home_o = home_q;
  end

endmodule

// ----- hdl/lpht_dp.sv -----
// ----------------------------------------------------------------------------
// lpht_dp: hash table datapath
// Request latch, key normalization, slot RAMs, probe index, live count,
// limit register and response register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpht_dp #(
  parameter int SLOTS       = 256,
  parameter int KEY_BYTES   = 8,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lpht_pkg::CNT_W-1:0]    cfg_wdata_i,
  input  logic [lpht_pkg::KIND_W-1:0]   kind_i,
  input  logic [lpht_pkg::KEY_W-1:0]    key_i,
  input  logic [lpht_pkg::VAL_W-1:0]    value_i,
  input  lpht_pkg::ctl_cmd_t            cmd_i,
  output lpht_pkg::dp_stat_t            stat_o,
  input  logic                          rsp_ready_i,
  output logic                          rsp_valid_o,
  output logic                          found_o,
  output logic [lpht_pkg::VAL_W-1:0]    value_out_o,
  output logic [lpht_pkg::STAT_W-1:0]   status_o,
  output logic [lpht_pkg::CNT_W-1:0]    entry_count_o
);

  localparam int IDXW   = $clog2(SLOTS);
  localparam int KW     = 8 * KEY_BYTES;
  localparam int OUTW   = lpht_pkg::VAL_W;
  localparam int KEYIW  = lpht_pkg::KEY_W;
  localparam int CW     = lpht_pkg::CNT_W;
  localparam int MW     = lpht_pkg::MARK_W;
  localparam int SW     = (VALUE_WIDTH < OUTW) ? VALUE_WIDTH : OUTW;
  localparam logic [IDXW-1:0] LAST_IDX = IDXW'(SLOTS - 1);

  logic [KEYIW-1:0]             key_norm;
  logic                         alive;
  logic [lpht_pkg::KIND_W-1:0]  kind_q;
  logic [KW-1:0]                key_q;
  logic [SW-1:0]                val_q;
  logic [IDXW-1:0]              idx_q, idx_next, home;
  logic [IDXW-1:0]              n_q;
  logic [IDXW-1:0]              free_idx_q;
  logic                         free_valid_q, found_q;
  logic [CW-1:0]                live_q, count_d, max_q;
  logic                         out_valid_q;
  logic                         hash_done;
  logic [IDXW-1:0]              rd_addr, wr_addr;
  logic [MW-1:0]                mark_wdata, mark_rdata;
  logic [KW-1:0]                key_rdata;
  logic [SW-1:0]                val_rdata;

  // keep bytes up to the first zero byte and below KEY_BYTES
  always_comb begin
    key_norm = '0;
    alive    = 1'b1;
    for (int i = 0; i < KEYIW / 8; i++) begin
      if (i >= KEY_BYTES || key_i[8*i +: 8] == 8'd0) begin
        alive = 1'b0;
      end
      if (alive) begin
        key_norm[8*i +: 8] = key_i[8*i +: 8];
      end
    end
  end

  lpht_hash #(.SLOTS(SLOTS), .KEY_BYTES(KEY_BYTES)) u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.load),
    .key_i   (key_norm),
    .done_o  (hash_done),
    .home_o  (home)
  );

  assign idx_next = (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;

  // read the next slot early so that one probe completes each cycle
  always_comb begin
    priority if (cmd_i.load_home) rd_addr = home;
    else if (cmd_i.advance)       rd_addr = idx_next;
    else                          rd_addr = idx_q;
  end

  assign wr_addr    = cmd_i.wsel_free ? free_idx_q : idx_q;
  assign mark_wdata = cmd_i.clr_step ? lpht_pkg::MARK_EMPTY : cmd_i.mark;

  lpht_ram #(.WIDTH(MW), .DEPTH(SLOTS)) u_mark_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_mark | cmd_i.clr_step),
    .waddr_i (wr_addr),
    .wdata_i (mark_wdata),
    .raddr_i (rd_addr),
    .rdata_o (mark_rdata)
  );

  lpht_ram #(.WIDTH(KW), .DEPTH(SLOTS)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_key),
    .waddr_i (wr_addr),
    .wdata_i (key_q),
    .raddr_i (rd_addr),
    .rdata_o (key_rdata)
  );

  lpht_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_val),
    .waddr_i (wr_addr),
    .wdata_i (val_q),
    .raddr_i (rd_addr),
    .rdata_o (val_rdata)
  );

  always_comb begin
    count_d = live_q;
    if (cmd_i.cnt_inc) begin
      count_d = live_q + 1'b1;
    end else if (cmd_i.cnt_dec && live_q != '0) begin
      count_d = live_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q        <= '0;
      n_q          <= '0;
      free_valid_q <= 1'b0;
      found_q      <= 1'b0;
      live_q       <= '0;
      max_q        <= lpht_pkg::MAX_ENTRIES_RST;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_q <= cfg_wdata_i;
      end
      if (cmd_i.clr_step || cmd_i.advance) begin
        idx_q <= idx_next;
      end else if (cmd_i.load_home) begin
        idx_q <= home;
      end
      if (cmd_i.load_home) begin
        n_q          <= '0;
        free_valid_q <= 1'b0;
        found_q      <= 1'b0;
      end else if (cmd_i.probe) begin
        if (cmd_i.advance) begin
          n_q <= n_q + 1'b1;
        end
        if (mark_rdata != lpht_pkg::MARK_LIVE) begin
          free_valid_q <= 1'b1;
        end
        found_q <= (mark_rdata == lpht_pkg::MARK_LIVE) && (key_rdata == key_q);
      end
      if (cmd_i.commit) begin
        live_q <= count_d;
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= kind_i;
      key_q  <= key_norm[KW-1:0];
      val_q  <= value_i[SW-1:0];
    end
    if (cmd_i.probe && !free_valid_q && mark_rdata != lpht_pkg::MARK_LIVE) begin
      free_idx_q <= idx_q;
    end
    if (cmd_i.commit) begin
      found_o       <= found_q;
      value_out_o   <= cmd_i.vout_sel ? OUTW'(val_rdata) : '0;
      status_o      <= cmd_i.status;
      entry_count_o <= count_d;
    end
  end

  assign rsp_valid_o = out_valid_q;

  always_comb begin
    stat_o            = '0;
    stat_o.hash_done  = hash_done;
    stat_o.mark_live  = (mark_rdata == lpht_pkg::MARK_LIVE);
    stat_o.mark_empty = (mark_rdata == lpht_pkg::MARK_EMPTY);
    stat_o.key_match  = (key_rdata == key_q);
    stat_o.last_probe = (n_q == LAST_IDX);
    stat_o.last_idx   = (idx_q == LAST_IDX);
    stat_o.found      = found_q;
    stat_o.free_valid = free_valid_q;
    stat_o.full       = (live_q >= max_q);
    stat_o.out_free   = !out_valid_q || rsp_ready_i;
    stat_o.kind       = kind_q;
  end

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> (!out_valid_q || rsp_ready_i))
    else $error("response register overwritten while a beat is pending");

  a_count_on_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (live_q != $past(live_q)) |-> $past(cmd_i.commit))
    else $error("live count changed outside a commit");

endmodule

// ----- hdl/lpht_ctrl.sv -----
// ----------------------------------------------------------------------------
// lpht_ctrl: hash table controller
// Sequences clearing, hashing, probing and commit of each request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpht_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  output logic               req_ready_o,
  input  lpht_pkg::dp_stat_t stat_i,
  output lpht_pkg::ctl_cmd_t cmd_o
);

  lpht_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lpht_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      lpht_pkg::ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.last_idx) state_d = lpht_pkg::ST_IDLE;
      end
      lpht_pkg::ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = lpht_pkg::ST_HASH;
        end
      end
      lpht_pkg::ST_HASH: begin
        if (stat_i.hash_done) begin
          cmd_o.load_home = 1'b1;
          state_d         = lpht_pkg::ST_PROBE;
        end
      end
      lpht_pkg::ST_PROBE: begin
        cmd_o.probe = 1'b1;
        // stop at an empty slot, a live match, or after a full lap
        if (stat_i.mark_empty || (stat_i.mark_live && stat_i.key_match) ||
            stat_i.last_probe) begin
          state_d = lpht_pkg::ST_COMMIT;
        end else begin
          cmd_o.advance = 1'b1;
        end
      end
      lpht_pkg::ST_COMMIT: begin
        if (stat_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = lpht_pkg::ST_IDLE;
          unique case (stat_i.kind)
            lpht_pkg::KIND_SET: begin
              if (stat_i.found) begin
                cmd_o.wr_val = 1'b1;
                cmd_o.status = lpht_pkg::STATUS_DONE;
              end else if (stat_i.full || !stat_i.free_valid) begin
                cmd_o.status = lpht_pkg::STATUS_FULL;
              end else begin
                cmd_o.wr_key    = 1'b1;
                cmd_o.wr_val    = 1'b1;
                cmd_o.wr_mark   = 1'b1;
                cmd_o.mark      = lpht_pkg::MARK_LIVE;
                cmd_o.wsel_free = 1'b1;
                cmd_o.cnt_inc   = 1'b1;
                cmd_o.status    = lpht_pkg::STATUS_DONE;
              end
            end
            lpht_pkg::KIND_REMOVE: begin
              if (stat_i.found) begin
                cmd_o.wr_mark = 1'b1;
                cmd_o.mark    = lpht_pkg::MARK_TOMB;
                cmd_o.cnt_dec = 1'b1;
                cmd_o.status  = lpht_pkg::STATUS_DONE;
              end else begin
                cmd_o.status = lpht_pkg::STATUS_ABSENT;
              end
            end
            lpht_pkg::KIND_GET, lpht_pkg::KIND_RSVD: begin
              // the reserved code reads like a get
              if (stat_i.found) begin
                cmd_o.vout_sel = 1'b1;
                cmd_o.status   = lpht_pkg::STATUS_DONE;
              end else begin
                cmd_o.status = lpht_pkg::STATUS_ABSENT;
              end
            end
            default: begin
              cmd_o.status = lpht_pkg::STATUS_ABSENT;
            end
          endcase
        end
      end
      default: begin
        state_d = lpht_pkg::ST_CLEAR;
      end
    endcase
  end

  a_lap_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.advance |-> !stat_i.last_probe)
    else $error("probe advanced past a full lap of the table");

  a_insert_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.wr_mark && cmd_o.mark == lpht_pkg::MARK_LIVE) |->
      (cmd_o.wsel_free && stat_i.free_valid && !stat_i.found && !stat_i.full))
    else $error("insert without a free slot or over the entry limit");

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lpht_pkg::ST_CLEAR) |-> !req_ready_o && !cmd_o.commit)
    else $error("request taken or result given during the clearing pass");

endmodule

// ----- dv/lpht_rsp_checker.sv -----
// ----------------------------------------------------------------------------
// lpht_rsp_checker: response predictor and comparator for the hash table
// Watches the configuration port and both channels, keeps its own copy of the
// slot store, predicts one response per request beat and compares responses
// in order, field by field. Hands the outstanding count and failures upward.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpht_rsp_checker #(
  parameter int SLOTS       = 256,
  parameter int KEY_BYTES   = 8,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [lpht_pkg::CNT_W-1:0] cfg_wdata_i,
  lpht_req_if                        req_i,
  lpht_rsp_if                        rsp_i,
  output int                         pending_o,
  output int                         fail_count_o
);
  import lpht_pkg::*;

  typedef struct packed {
    logic              found;
    logic [VAL_W-1:0]  value_out;
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  count;
  } rsp_beat_t;

  localparam logic [63:0] VAL_MASK64 =
    (VALUE_WIDTH >= 64) ? '1 : (64'd1 << VALUE_WIDTH) - 64'd1;

  logic [KEY_W-1:0] slot_key_q  [SLOTS];
  logic [VAL_W-1:0] slot_val_q  [SLOTS];
  mark_e            slot_mark_q [SLOTS];
  int               live_entries;
  int               entry_limit;
  int               fails;
  rsp_beat_t        expected_rsps [$];

  // Cut the key at its first zero byte and fold the kept bytes into djb2.
  function automatic logic [KEY_W-1:0] trim_key(input logic [KEY_W-1:0] raw,
                                                output logic [HASH_W-1:0] hash);
    logic [KEY_W-1:0] kept;
    logic [7:0]       b;
    bit               stop;
    kept = '0;
    hash = DJB2_SEED;
    stop = 1'b0;
    for (int i = 0; i < KEY_BYTES && i < 8; i++) begin
      b = raw[8*i +: 8];
      if (b == 8'd0) stop = 1'b1;
      if (!stop) begin
        kept[8*i +: 8] = b;
        hash = (hash << 5) + hash + HASH_W'(b);
      end
    end
    return kept;
  endfunction

  // Apply one operation to the shadow table and return its response beat.
  function automatic rsp_beat_t table_op(input logic [KIND_W-1:0] kind,
                                         input logic [KEY_W-1:0]  raw_key,
                                         input logic [VAL_W-1:0]  value);
    rsp_beat_t         r;
    logic [KEY_W-1:0]  key;
    logic [HASH_W-1:0] hash;
    int                idx;
    int                hit;
    int                free_slot;
    key       = trim_key(raw_key, hash);
    idx       = int'(hash % 64'(SLOTS));
    hit       = -1;
    free_slot = -1;
    // Walk forward past tombstones; stop on the key or an empty slot.
    for (int n = 0; n < SLOTS; n++) begin
      if (slot_mark_q[idx] == MARK_EMPTY) begin
        if (free_slot < 0) free_slot = idx;
        break;
      end
      if (slot_mark_q[idx] == MARK_LIVE) begin
        if (slot_key_q[idx] == key) begin
          hit = idx;
          break;
        end
      end else if (free_slot < 0) begin
        free_slot = idx;
      end
      idx = (idx + 1) % SLOTS;
    end
    r = '0;
    case (kind)
      KIND_SET: begin
        if (hit >= 0) begin
          slot_val_q[hit] = value & VAL_MASK64[VAL_W-1:0];
        end else if (live_entries >= entry_limit || free_slot < 0) begin
          r.status = STATUS_FULL;
        end else begin
          slot_key_q[free_slot]  = key;
          slot_val_q[free_slot]  = value & VAL_MASK64[VAL_W-1:0];
          slot_mark_q[free_slot] = MARK_LIVE;
          live_entries++;
        end
      end
      KIND_REMOVE: begin
        if (hit >= 0) begin
          slot_mark_q[hit] = MARK_TOMB;
          if (live_entries > 0) live_entries--;
        end else begin
          r.status = STATUS_ABSENT;
        end
      end
      default: begin
        if (hit >= 0) r.value_out = slot_val_q[hit] & VAL_MASK64[VAL_W-1:0];
        else r.status = STATUS_ABSENT;
      end
    endcase
    r.found = (hit >= 0);
    r.count = CNT_W'(live_entries);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_beat_t want;
    rsp_beat_t got;
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) slot_mark_q[i] = MARK_EMPTY;
      live_entries = 0;
      entry_limit  = int'(MAX_ENTRIES_RST);
      fails        = 0;
      expected_rsps.delete();
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (cfg_we_i) entry_limit = int'(cfg_wdata_i);
      // Retire the response first: it always belongs to an older request.
      if (rsp_i.valid && rsp_i.ready) begin
        got = {rsp_i.found, rsp_i.value_out, rsp_i.status, rsp_i.entry_count_out};
        if (expected_rsps.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("[%0t] unexpected response beat: found=%0d value=%h status=%0d count=%0d",
                     $time, got.found, got.value_out, got.status, got.count);
        end else begin
          want = expected_rsps.pop_front();
          if (got.found !== want.found || got.value_out !== want.value_out ||
              got.status !== want.status || got.count !== want.count) begin
            fails++;
            if (fails <= 10)
              $display({"[%0t] mismatch: exp found=%0d value=%h status=%0d count=%0d",
                        " | got found=%0d value=%h status=%0d count=%0d"},
                       $time, want.found, want.value_out, want.status, want.count,
                       got.found, got.value_out, got.status, got.count);
          end
        end
      end
      if (req_i.valid && req_i.ready)
        expected_rsps.push_back(table_op(req_i.kind, req_i.key, req_i.value));
      pending_o    <= expected_rsps.size();
      fail_count_o <= fails;
    end
  end

endmodule

// ----- dv/tb_linear_probe_hash_table_core.sv -----
// ----------------------------------------------------------------------------
// tb_linear_probe_hash_table_core: testbench top for the hash table core
// Drives get, set and remove requests: a directed pass over empty keys,
// padded keys, colliding probe chains and tombstones, then random traffic
// under several entry limits and idle patterns, and a pass that fills every
// slot. The checker beside the block predicts and compares each response.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_linear_probe_hash_table_core;
  import lpht_pkg::*;

  localparam int SLOTS       = 256;
  localparam int KEY_BYTES   = 8;
  localparam int VALUE_WIDTH = 32;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int POOL_SIZE   = 48;
  localparam int CHUNK_ITEMS = 180;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [CNT_W-1:0] cfg_wdata;
  int               send_idle_pct;
  int               recv_idle_pct;
  int               pending;
  int               fail_count;
  int               cycles = 0;
  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  lpht_req_if req_if ();
  lpht_rsp_if rsp_if ();

  linear_probe_hash_table_core #(
    .SLOTS      (SLOTS),
    .KEY_BYTES  (KEY_BYTES),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  lpht_rsp_checker #(
    .SLOTS      (SLOTS),
    .KEY_BYTES  (KEY_BYTES),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_if),
    .rsp_i       (rsp_if),
    .pending_o   (pending),
    .fail_count_o(fail_count)
  );

  always #5 clk = ~clk;

  // Bail out if the run hangs: a lost response or a stuck handshake.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Stall the response side at the current idle rate, one draw per cycle.
  always @(posedge clk) begin
    rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Two-byte keys that share a home slot: raising the first character by one
  // adds 33 to the hash, lowering the second by 33 takes it back.
  function automatic logic [KEY_W-1:0] family_key(input int base, input int k);
    logic [7:0] b0;
    logic [7:0] b1;
    b0 = 8'(base + k);
    b1 = 8'(255 - 33 * k);
    return {48'd0, b1, b0};
  endfunction

  // Mix chain keys, reusable keys, keys with junk past the terminator, empty
  // keys and raw noise, so lookups hit often and every key bit toggles.
  function automatic logic [KEY_W-1:0] pick_key();
    logic [KEY_W-1:0] k;
    logic [KEY_W-1:0] junk;
    int               len;
    k    = key_pool[$urandom_range(POOL_SIZE - 1)];
    junk = {$urandom, $urandom};
    len  = $urandom_range(1, 7);
    case ($urandom_range(9))
      0, 1, 2, 3: k = family_key(1 + 60 * $urandom_range(3), $urandom_range(7));
      4, 5, 6:    k = k;
      7: begin
        k = (k & ((64'd1 << (8 * len)) - 64'd1)) |
            (junk & ~((64'd1 << (8 * (len + 1))) - 64'd1));
      end
      8:       k = junk & ~64'hFF;
      default: k = junk;
    endcase
    return k;
  endfunction

  // Hold the request side until every outstanding response has come back.
  task automatic wait_drain();
    do @(posedge clk); while (pending != 0);
  endtask

  // Present one request beat and hold it until accepted, then maybe idle.
  task automatic push_op(input logic [KIND_W-1:0] kind, input logic [KEY_W-1:0] key,
                         input logic [VAL_W-1:0] value);
    req_if.valid <= 1'b1;
    req_if.kind  <= kind;
    req_if.key   <= key;
    req_if.value <= value;
    do @(posedge clk); while (!req_if.ready);
    if ($urandom_range(149) == 0) begin
      req_if.valid <= 1'b0;
      wait_drain();
    end else if ($urandom_range(99) < send_idle_pct) begin
      // Drop valid and scramble the payload while idle.
      req_if.valid <= 1'b0;
      req_if.kind  <= KIND_W'($urandom);
      req_if.key   <= {$urandom, $urandom};
      req_if.value <= $urandom;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  // Write the entry limit only once the block has gone idle.
  task automatic write_limit(input logic [CNT_W-1:0] limit);
    req_if.valid <= 1'b0;
    wait_drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= limit;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(input int items);
    int               r;
    logic [KIND_W-1:0] kind;
    for (int i = 0; i < items; i++) begin
      r = $urandom_range(99);
      if (r < 35)      kind = KIND_GET;
      else if (r < 70) kind = KIND_SET;
      else if (r < 95) kind = KIND_REMOVE;
      else             kind = KIND_RSVD;
      push_op(kind, pick_key(), $urandom);
    end
  endtask

  initial begin
    req_if.valid  <= 1'b0;
    req_if.kind   <= KIND_GET;
    req_if.key    <= '0;
    req_if.value  <= '0;
    cfg_we        <= 1'b0;
    cfg_wdata     <= '0;
    rst_n         <= 1'b0;
    send_idle_pct = 24;
    recv_idle_pct = 54;

    // Build reusable keys of random length with no zero byte inside.
    foreach (key_pool[i]) begin
      key_pool[i] = '0;
      for (int b = 0; b < $urandom_range(1, 8); b++)
        key_pool[i][8*b +: 8] = 8'($urandom_range(1, 255));
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed pass at the reset limit: empty table, the empty key, padding
    // junk, an all-ones key, a probe chain with a tombstone in the middle.
    push_op(KIND_GET,    family_key(1, 0), 32'h1234_5678);
    push_op(KIND_REMOVE, family_key(1, 0), 32'h0);
    push_op(KIND_SET,    64'h0,                  32'hFFFF_FFFF);
    push_op(KIND_GET,    64'hFFFF_FFFF_FFFF_FF00, 32'h0);
    push_op(KIND_SET,    64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
    push_op(KIND_GET,    64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    push_op(KIND_SET,    64'hA5A5_5A5A_5A00_6261, 32'h0000_0001);
    push_op(KIND_GET,    64'h0000_0000_0000_6261, 32'h0);
    for (int k = 0; k < 4; k++)
      push_op(KIND_SET, family_key(1, k), 32'hC0DE_0000 + k);
    push_op(KIND_GET,    family_key(1, 3), 32'h0);
    push_op(KIND_REMOVE, family_key(1, 1), 32'h0);
    push_op(KIND_GET,    family_key(1, 3), 32'h0);
    push_op(KIND_GET,    family_key(1, 1), 32'h0);
    push_op(KIND_SET,    family_key(1, 4), 32'h5555_AAAA);
    push_op(KIND_SET,    family_key(1, 2), 32'hAAAA_5555);
    push_op(KIND_RSVD,   family_key(1, 2), 32'h0);
    push_op(KIND_REMOVE, family_key(1, 0), 32'h0);
    push_op(KIND_RSVD,   family_key(1, 7), 32'h0);
    push_op(KIND_SET,    64'h8000_0000_0000_0001, 32'h8000_0001);

    // Limit zero: refuse inserts, keep updates and removes working.
    write_limit(9'd0);
    push_op(KIND_SET,    family_key(1, 6), 32'h1);
    push_op(KIND_SET,    family_key(1, 2), 32'h2);
    push_op(KIND_REMOVE, family_key(1, 2), 32'h0);
    push_op(KIND_SET,    family_key(1, 2), 32'h3);

    // Random traffic, sender idling less than the receiver.
    write_limit(9'd1);
    run_random(CHUNK_ITEMS);
    write_limit(9'd37);
    run_random(CHUNK_ITEMS);

    // Swap the idle rates.
    send_idle_pct = 54;
    recv_idle_pct <= 24;
    write_limit(9'd204);
    run_random(CHUNK_ITEMS);
    write_limit(9'd5);
    run_random(CHUNK_ITEMS);

    // No idling from here on.
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    write_limit(9'd150);
    run_random(CHUNK_ITEMS);

    // Fill every slot with fresh three-byte keys, then miss in a full table.
    write_limit(9'd256);
    for (int i = 0; i < 300; i++)
      push_op(KIND_SET, {40'd0, 8'(i / 255 + 1), 8'(i % 255 + 1), 8'hC3}, $urandom);
    push_op(KIND_GET,    64'h7A7A_7A7A_7A7A_7A7A, 32'h0);
    push_op(KIND_REMOVE, 64'h7A7A_7A7A_7A7A_7A7A, 32'h0);

    // Raise the limit past the slot count: refusal now comes from no free slot.
    write_limit(9'h1FF);
    push_op(KIND_SET, 64'h7A7A_7A7A_7A7A_7A7A, 32'h7A7A_7A7A);
    for (int i = 0; i < 40; i++)
      push_op(KIND_REMOVE, {40'd0, 8'd1, 8'(i * 7 % 255 + 1), 8'hC3}, 32'h0);
    run_random(150);

    // Limit below the live count: every insert refused.
    write_limit(9'd204);
    run_random(CHUNK_ITEMS);

    req_if.valid <= 1'b0;
    wait_drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/lpht_pkg.sv
hdl/lpht_if.sv
hdl/lpht_ram.sv
hdl/lpht_hash.sv
hdl/lpht_dp.sv
hdl/lpht_ctrl.sv
hdl/linear_probe_hash_table_core.sv
dv/lpht_rsp_checker.sv
dv/tb_linear_probe_hash_table_core.sv
